### hdl/mains_voltage_supervisor_macros.svh
// Assertion helpers for the supervisor RTL.
`ifndef MAINS_VOLTAGE_SUPERVISOR_MACROS_SVH
`define MAINS_VOLTAGE_SUPERVISOR_MACROS_SVH

// Clocked assertion with reset gating and a fixed message.
`define MVS_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with a generic message.
`define MVS_ASSERT(lbl, clk, rst_n, prop) \
  `MVS_ASSERT_MSG(lbl, clk, rst_n, prop, "supervisor assertion failed")

`endif

### hdl/mvs_pkg.sv
`timescale 1ns / 1ps

package mvs_pkg;

  // Default parameter values.
  localparam int unsigned TripDelayDef      = 100;
  localparam int unsigned PowerfailDelayDef = 2;
  localparam int unsigned DeadLevelDef      = 20;
  localparam int unsigned RestoreLevelDef   = 40;

  localparam int unsigned LevelW  = 8;
  localparam int unsigned SampleW = 10;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values.
  localparam logic [LevelW-1:0] HighTripRst    = 8'd250;
  localparam logic [LevelW-1:0] LowTripRst     = 8'd170;
  localparam logic [LevelW-1:0] HighReleaseRst = 8'd245;
  localparam logic [LevelW-1:0] LowReleaseRst  = 8'd180;

  typedef enum logic [CfgIdxW-1:0] {
    RegHighTrip    = 2'd0,
    RegLowTrip     = 2'd1,
    RegHighRelease = 2'd2,
    RegLowRelease  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] high_trip;
    logic [LevelW-1:0] low_trip;
    logic [LevelW-1:0] high_release;
    logic [LevelW-1:0] low_release;
  } cfg_t;

  typedef struct packed {
    logic high_error;
    logic low_error;
    logic high_event;
    logic low_event;
    logic power_lost;
    logic reset_request;
    logic powered;
  } result_t;

endpackage

### hdl/mvs_cfg.sv
`timescale 1ns / 1ps

module mvs_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [mvs_pkg::CfgIdxW-1:0]     wr_idx_i,
  input  logic [mvs_pkg::LevelW-1:0]      wr_data_i,
  output mvs_pkg::cfg_t                   cfg_o
);

  mvs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (mvs_pkg::cfg_idx_e'(wr_idx_i))
        mvs_pkg::RegHighTrip:    cfg_d.high_trip    = wr_data_i;
        mvs_pkg::RegLowTrip:     cfg_d.low_trip     = wr_data_i;
        mvs_pkg::RegHighRelease: cfg_d.high_release = wr_data_i;
        mvs_pkg::RegLowRelease:  cfg_d.low_release  = wr_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_trip    <= mvs_pkg::HighTripRst;
      cfg_q.low_trip     <= mvs_pkg::LowTripRst;
      cfg_q.high_release <= mvs_pkg::HighReleaseRst;
      cfg_q.low_release  <= mvs_pkg::LowReleaseRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/mvs_core.sv
`timescale 1ns / 1ps

module mvs_core #(
  parameter int unsigned TRIP_DELAY      = mvs_pkg::TripDelayDef,
  parameter int unsigned POWERFAIL_DELAY = mvs_pkg::PowerfailDelayDef,
  parameter int unsigned DEAD_LEVEL      = mvs_pkg::DeadLevelDef,
  parameter int unsigned RESTORE_LEVEL   = mvs_pkg::RestoreLevelDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [mvs_pkg::SampleW-1:0]  sample_i,
  input  mvs_pkg::cfg_t                cfg_i,
  output mvs_pkg::result_t             res_o
);

  // Trip counters saturate one past their limit.
  localparam int unsigned TripW = $clog2(TRIP_DELAY + 2);
  localparam int unsigned DeadW = $clog2(POWERFAIL_DELAY + 2);
  localparam logic [TripW-1:0] TripLim = TripW'(TRIP_DELAY);
  localparam logic [DeadW-1:0] DeadLim = DeadW'(POWERFAIL_DELAY);
  localparam logic [mvs_pkg::SampleW-1:0] DeadLvl    = mvs_pkg::SampleW'(DEAD_LEVEL);
  localparam logic [mvs_pkg::SampleW-1:0] RestoreLvl = mvs_pkg::SampleW'(RESTORE_LEVEL);

  logic             powered_q, powered_d;
  logic             lost_q, lost_d;
  logic             high_err_q, high_err_d;
  logic             low_err_q, low_err_d;
  logic [TripW-1:0] high_cnt_q, high_cnt_d;
  logic [TripW-1:0] low_cnt_q, low_cnt_d;
  logic [DeadW-1:0] dead_cnt_q, dead_cnt_d;

  logic [mvs_pkg::SampleW-1:0] high_trip, low_trip, high_rel, low_rel;
  logic [TripW-1:0] high_inc, low_inc;
  logic [DeadW-1:0] dead_inc;

  assign high_trip = {2'b00, cfg_i.high_trip};
  assign low_trip  = {2'b00, cfg_i.low_trip};
  assign high_rel  = {2'b00, cfg_i.high_release};
  assign low_rel   = {2'b00, cfg_i.low_release};

  assign high_inc = (high_cnt_q <= TripLim) ? high_cnt_q + TripW'(1) : high_cnt_q;
  assign low_inc  = (low_cnt_q  <= TripLim) ? low_cnt_q  + TripW'(1) : low_cnt_q;
  assign dead_inc = (dead_cnt_q <= DeadLim) ? dead_cnt_q + DeadW'(1) : dead_cnt_q;

  always_comb begin
    powered_d  = powered_q;
    lost_d     = lost_q;
    high_err_d = high_err_q;
    low_err_d  = low_err_q;
    high_cnt_d = high_cnt_q;
    low_cnt_d  = low_cnt_q;
    dead_cnt_d = dead_cnt_q;
    res_o      = '0;

    if (powered_q) begin
      if (sample_i >= high_trip) begin
        if (!high_err_q) begin
          high_cnt_d = high_inc;
          if (high_inc > TripLim) begin
            high_err_d       = 1'b1;
            res_o.high_event = 1'b1;
          end
        end
      end else begin
        high_cnt_d = '0;
      end

      if (sample_i <= low_trip) begin
        if (!low_err_q) begin
          low_cnt_d = low_inc;
          if (low_inc > TripLim) begin
            low_err_d       = 1'b1;
            res_o.low_event = 1'b1;
          end
        end
      end else begin
        low_cnt_d = '0;
      end

      // Inside the release window both errors clear, even if one just latched.
      if (sample_i <= high_rel && sample_i >= low_rel) begin
        high_err_d = 1'b0;
        low_err_d  = 1'b0;
      end

      if (sample_i < DeadLvl) begin
        dead_cnt_d = dead_inc;
        if (dead_inc > DeadLim) begin
          powered_d        = 1'b0;
          lost_d           = 1'b1;
          res_o.power_lost = 1'b1;
        end
      end else begin
        dead_cnt_d = '0;
      end
    end else begin
      if (sample_i >= low_rel) begin
        powered_d = 1'b1;
      end
      res_o.reset_request = (sample_i > RestoreLvl) && lost_q;
    end

    res_o.high_error = high_err_d;
    res_o.low_error  = low_err_d;
    res_o.powered    = powered_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powered_q  <= 1'b0;
      lost_q     <= 1'b0;
      high_err_q <= 1'b0;
      low_err_q  <= 1'b0;
      high_cnt_q <= '0;
      low_cnt_q  <= '0;
      dead_cnt_q <= '0;
    end else if (step_i) begin
      powered_q  <= powered_d;
      lost_q     <= lost_d;
      high_err_q <= high_err_d;
      low_err_q  <= low_err_d;
      high_cnt_q <= high_cnt_d;
      low_cnt_q  <= low_cnt_d;
      dead_cnt_q <= dead_cnt_d;
    end
  end

endmodule

### hdl/mains_voltage_supervisor.sv
`timescale 1ns / 1ps
// A sample's result is written into the result register from the sample register once
// the result register is free, and it leaves on the result channel from there.
// Throughput: one sample per cycle; the sample register and the result register each
// hold one item, and the input stalls only while both are full and the output stalls.
// Reset (rst_ni, asynchronous, active low) empties both stages, clears all supervisor
// state to unpowered with no errors, and loads the threshold registers with defaults.
`include "mains_voltage_supervisor_macros.svh"

module mains_voltage_supervisor #(
  parameter int unsigned TRIP_DELAY      = mvs_pkg::TripDelayDef,
  parameter int unsigned POWERFAIL_DELAY = mvs_pkg::PowerfailDelayDef,
  parameter int unsigned DEAD_LEVEL      = mvs_pkg::DeadLevelDef,
  parameter int unsigned RESTORE_LEVEL   = mvs_pkg::RestoreLevelDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  // Sample channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mvs_pkg::SampleW-1:0]  voltage_sample_i,

  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         high_error_o,
  output logic                         low_error_o,
  output logic                         high_event_o,
  output logic                         low_event_o,
  output logic                         power_lost_o,
  output logic                         reset_request_o,
  output logic                         powered_o,

  // Threshold register writes.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mvs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mvs_pkg::LevelW-1:0]   cfg_data_i
);

  // Sample stage: holds one accepted sample until the result register can take its result.
  logic                         s1_valid_q, s1_valid_d;
  logic [mvs_pkg::SampleW-1:0]  sample_q, sample_d;
  // Result stage.
  logic                         out_valid_q, out_valid_d;
  mvs_pkg::result_t             res_q, res_d;

  logic             out_free;
  logic             step;
  logic             in_xfer;
  logic             any_event;
  mvs_pkg::cfg_t    cfg;
  mvs_pkg::result_t core_res;

  // The result register is free when empty or when its result leaves this cycle.
  assign out_free   = !(out_valid_q && out_stall_i);
  // Processing a sample commits the supervisor state, so it happens exactly once,
  // on the cycle its result is written into the result register.
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Writes are always accepted; the user must issue them only while the block is idle.
  assign cfg_ready_o = 1'b1;

  mvs_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  mvs_core #(
    .TRIP_DELAY      (TRIP_DELAY),
    .POWERFAIL_DELAY (POWERFAIL_DELAY),
    .DEAD_LEVEL      (DEAD_LEVEL),
    .RESTORE_LEVEL   (RESTORE_LEVEL)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (sample_q),
    .cfg_i    (cfg),
    .res_o    (core_res)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;

    // The sample stage refills whenever it is empty or its sample moves on.
    if (!s1_valid_q || out_free) begin
      s1_valid_d = in_xfer;
    end
    if (in_xfer) begin
      sample_d = voltage_sample_i;
    end

    if (step) begin
      out_valid_d = 1'b1;
      res_d       = core_res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    res_q    <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign high_error_o    = res_q.high_error;
  assign low_error_o     = res_q.low_error;
  assign high_event_o    = res_q.high_event;
  assign low_event_o     = res_q.low_event;
  assign power_lost_o    = res_q.power_lost;
  assign reset_request_o = res_q.reset_request;
  assign powered_o       = res_q.powered;

  // Any of the pulses that only a powered tick can raise.
  assign any_event = power_lost_o || high_event_o || low_event_o;

  // A power loss always leaves the block unpowered.
  `MVS_ASSERT(a_lost_unpowered, clk_i, rst_ni, out_valid_o && power_lost_o |-> !powered_o)

  // A reset request comes only from an unpowered tick, where no trip logic runs.
  `MVS_ASSERT(a_rreq_alone, clk_i, rst_ni, out_valid_o && reset_request_o |-> !any_event)

  // The input stalls only when both stages are full and the output is stalled.
  `MVS_ASSERT(a_stall_full, clk_i, rst_ni, in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)

  // A new result only appears after a sample sat in the sample stage.
  `MVS_ASSERT(a_result_source, clk_i, rst_ni, $rose(out_valid_o) |-> $past(s1_valid_q))

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the mains voltage supervisor. A driver process offers
// voltage samples from a queue that the main sequence fills, and predicts each
// result at the moment its transfer is accepted. A monitor process stalls the
// result channel at random and compares every result transfer with the oldest
// prediction, field by field.
module tb;

  // The block is built with its default parameters, so the bench uses the same values.
  localparam int unsigned TripDelay      = mvs_pkg::TripDelayDef;
  localparam int unsigned PowerfailDelay = mvs_pkg::PowerfailDelayDef;
  localparam int unsigned DeadLevel      = mvs_pkg::DeadLevelDef;
  localparam int unsigned RestoreLevel   = mvs_pkg::RestoreLevelDef;

  // Two register stages, so the settle time covers anything still in flight.
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned HoldoffLen   = 80;
  localparam int unsigned PrintLimit   = 40;

  // Shapes of sample runs, most chosen relative to the current thresholds.
  typedef enum int unsigned {
    RunOver,
    RunUnder,
    RunWindow,
    RunDead,
    RunRestore,
    RunTripClear,
    RunAny
  } run_kind_e;

  logic                                clk_i            = 1'b0;
  logic                                rst_ni           = 1'b0;
  logic                                in_valid_i       = 1'b0;
  logic                                in_stall_o;
  logic [mvs_pkg::SampleW-1:0]         voltage_sample_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i      = 1'b0;
  logic                                high_error_o;
  logic                                low_error_o;
  logic                                high_event_o;
  logic                                low_event_o;
  logic                                power_lost_o;
  logic                                reset_request_o;
  logic                                powered_o;
  logic                                cfg_valid_i      = 1'b0;
  logic                                cfg_ready_o;
  logic [mvs_pkg::CfgIdxW-1:0]         cfg_index_i      = '0;
  logic [mvs_pkg::LevelW-1:0]          cfg_data_i       = '0;

  // Samples waiting to be offered, and the results predicted for accepted samples.
  logic [mvs_pkg::SampleW-1:0] sample_q [$];
  mvs_pkg::result_t            verdict_q [$];

  // Our own copy of the supervisor state and of the threshold registers.
  mvs_pkg::cfg_t levels;
  logic          mains_on;
  logic          was_lost;
  int unsigned   over_run;
  int unsigned   under_run;
  int unsigned   dead_run;
  logic          over_err;
  logic          under_err;

  // Idle rates in percent for each side, changed by the main sequence per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // The long receiver hold-off is armed by a one-cycle pulse and counted down here.
  logic        holdoff_go   = 1'b0;
  int unsigned holdoff_left = 0;

  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned over_trips   = 0;
  int unsigned under_trips  = 0;
  int unsigned losses       = 0;
  int unsigned restarts     = 0;
  int unsigned settings     = 1;

  // Opening samples, starting unpowered with the reset thresholds: a dead sample and a
  // low one that do nothing, power-up exactly at the low release level, both edges of
  // the trip and release levels, three dead samples for a power loss, the restore
  // level and one above it, power-up together with a reset request, one dead sample
  // straight after a restart (the dead count is kept), and walking bit patterns.
  logic [mvs_pkg::SampleW-1:0] opening [0:19] = '{
    10'd0,   10'd41,  10'd180, 10'd1023, 10'd250, 10'd245, 10'd170,
    10'd171, 10'd180, 10'd19,  10'd19,   10'd19,  10'd40,  10'd41,
    10'd682, 10'd5,   10'd512, 10'd20,   10'd341, 10'd200
  };

  mains_voltage_supervisor uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .voltage_sample_i(voltage_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .high_error_o    (high_error_o),
    .low_error_o     (low_error_o),
    .high_event_o    (high_event_o),
    .low_event_o     (low_event_o),
    .power_lost_o    (power_lost_o),
    .reset_request_o (reset_request_o),
    .powered_o       (powered_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the result of one sample and advances the predicted state. The trip
  // counters saturate one past their limit, a latched side stops counting, and a
  // sample inside the release window clears both errors even on the tick it trips.
  function automatic mvs_pkg::result_t supervise_sample(
    input logic [mvs_pkg::SampleW-1:0] sample
  );
    mvs_pkg::result_t res;
    int unsigned      s;
    res = '0;
    s   = sample;
    if (mains_on) begin
      if (s >= levels.high_trip) begin
        if (!over_err) begin
          if (over_run <= TripDelay) over_run++;
          if (over_run > TripDelay) begin
            over_err       = 1'b1;
            res.high_event = 1'b1;
          end
        end
      end else begin
        over_run = 0;
      end
      if (s <= levels.low_trip) begin
        if (!under_err) begin
          if (under_run <= TripDelay) under_run++;
          if (under_run > TripDelay) begin
            under_err     = 1'b1;
            res.low_event = 1'b1;
          end
        end
      end else begin
        under_run = 0;
      end
      if (s <= levels.high_release && s >= levels.low_release) begin
        over_err  = 1'b0;
        under_err = 1'b0;
      end
      if (s < DeadLevel) begin
        if (dead_run <= PowerfailDelay) dead_run++;
        if (dead_run > PowerfailDelay) begin
          mains_on       = 1'b0;
          was_lost       = 1'b1;
          res.power_lost = 1'b1;
        end
      end else begin
        dead_run = 0;
      end
    end else begin
      // Unpowered: counters and errors hold, and the request repeats after every loss.
      if (s >= levels.low_release) mains_on = 1'b1;
      if (s > RestoreLevel && was_lost) res.reset_request = 1'b1;
    end
    res.high_error = over_err;
    res.low_error  = under_err;
    res.powered    = mains_on;
    return res;
  endfunction

  // Draws one sample of the given shape against the current thresholds.
  function automatic logic [mvs_pkg::SampleW-1:0] pick_sample(input run_kind_e kind);
    int unsigned lo;
    int unsigned hi;
    lo = 0;
    hi = 1023;
    case (kind)
      RunOver: begin
        lo = levels.high_trip;
      end
      RunUnder: begin
        // Stay above the dead level where the trip level allows it, to keep power.
        hi = levels.low_trip;
        lo = (hi >= DeadLevel) ? DeadLevel : 0;
      end
      RunWindow: begin
        if (levels.low_release <= levels.high_release) begin
          lo = levels.low_release;
          hi = levels.high_release;
        end else begin
          hi = 255;
        end
      end
      RunDead: begin
        hi = DeadLevel - 1;
      end
      RunRestore: begin
        lo = RestoreLevel + 1;
        hi = (levels.low_release > lo) ? levels.low_release - 1 : 255;
      end
      RunTripClear: begin
        // Overvoltage and inside the release window at once, where the levels overlap.
        lo = (levels.high_trip > levels.low_release) ? levels.high_trip : levels.low_release;
        hi = levels.high_release;
        if (lo > hi) begin
          lo = 0;
          hi = 255;
        end
      end
      default: begin
      end
    endcase
    return mvs_pkg::SampleW'($urandom_range(hi, lo));
  endfunction

  task automatic add_run(input run_kind_e kind, input int unsigned len);
    repeat (len) sample_q.push_back(pick_sample(kind));
  endtask

  // Queues runs of random shape and length until the budget of samples is used.
  task automatic queue_runs(input int unsigned budget);
    int unsigned added;
    int unsigned roll;
    int unsigned len;
    run_kind_e   kind;
    added = 0;
    while (added < budget) begin
      roll = $urandom_range(99);
      if (roll < 20)      kind = RunOver;
      else if (roll < 40) kind = RunUnder;
      else if (roll < 62) kind = RunWindow;
      else if (roll < 74) kind = RunDead;
      else if (roll < 82) kind = RunRestore;
      else if (roll < 87) kind = RunTripClear;
      else                kind = RunAny;
      case (kind)
        RunDead: len = $urandom_range(5, 1);
        RunAny:  len = $urandom_range(3, 1);
        default: len = $urandom_range(12, 1);
      endcase
      add_run(kind, len);
      added += len;
    end
  endtask

  // One register write; our copy of the thresholds follows once the transfer is made.
  task automatic write_level(input mvs_pkg::cfg_idx_e idx,
                             input logic [mvs_pkg::LevelW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mvs_pkg::RegHighTrip:    levels.high_trip    = value;
      mvs_pkg::RegLowTrip:     levels.low_trip     = value;
      mvs_pkg::RegHighRelease: levels.high_release = value;
      mvs_pkg::RegLowRelease:  levels.low_release  = value;
      default: begin
      end
    endcase
  endtask

  task automatic apply_levels(input logic [mvs_pkg::LevelW-1:0] ht,
                              input logic [mvs_pkg::LevelW-1:0] lt,
                              input logic [mvs_pkg::LevelW-1:0] hr,
                              input logic [mvs_pkg::LevelW-1:0] lr);
    write_level(mvs_pkg::RegHighTrip, ht);
    write_level(mvs_pkg::RegLowTrip, lt);
    write_level(mvs_pkg::RegHighRelease, hr);
    write_level(mvs_pkg::RegLowRelease, lr);
    settings++;
  endtask

  // Returns once every queued sample has been accepted and every result has come back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintLimit) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_flag(input string name, input logic want, input logic got);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is %b, predicted %b",
                                results_seen, name, got, want));
    end
  endtask

  task automatic check_result();
    mvs_pkg::result_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch("result transfer with no sample outstanding");
    end else begin
      want = verdict_q.pop_front();
      compare_flag("high_error", want.high_error, high_error_o);
      compare_flag("low_error", want.low_error, low_error_o);
      compare_flag("high_event", want.high_event, high_event_o);
      compare_flag("low_event", want.low_event, low_event_o);
      compare_flag("power_lost", want.power_lost, power_lost_o);
      compare_flag("reset_request", want.reset_request, reset_request_o);
      compare_flag("powered", want.powered, powered_o);
      over_trips  += want.high_event;
      under_trips += want.low_event;
      losses      += want.power_lost;
      restarts    += want.reset_request;
    end
    results_seen++;
  endtask

  // Sample driver. A transfer seen at this edge is predicted at once, so predictions
  // stay in acceptance order. The valid and the sample are only touched when the
  // channel is free, so a stalled transfer keeps its payload.
  always @(posedge clk_i) begin : sample_driver
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) verdict_q.push_back(supervise_sample(voltage_sample_i));
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i       <= 1'b1;
          voltage_sample_i <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor. The stall for the next cycle is drawn after checking this edge.
  always @(posedge clk_i) begin : result_monitor
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      out_stall_i <= (holdoff_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : holdoff_counter
    if (holdoff_go) begin
      holdoff_left <= HoldoffLen;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("Timed out: no transfer for %0d cycles", QuietLimit);
      $display("FAIL mains_voltage_supervisor");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_sequence
    // Our copy starts where the block's reset leaves it: unpowered, no errors.
    levels    = '{high_trip: mvs_pkg::HighTripRst, low_trip: mvs_pkg::LowTripRst,
                  high_release: mvs_pkg::HighReleaseRst,
                  low_release: mvs_pkg::LowReleaseRst};
    mains_on  = 1'b0;
    was_lost  = 1'b0;
    over_run  = 0;
    under_run = 0;
    dead_run  = 0;
    over_err  = 1'b0;
    under_err = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset thresholds, sender idling a little and the receiver mostly stalling.
    // After the opening samples, full-length overvoltage and undervoltage runs latch
    // both errors; a latched side then stops counting until a window sample clears it.
    set_idling(12, 82);
    foreach (opening[i]) sample_q.push_back(opening[i]);
    add_run(RunOver, TripDelay + 6);
    add_run(RunWindow, 2);
    add_run(RunUnder, TripDelay + 6);
    add_run(RunOver, 3);
    queue_runs(30);
    wait_drained();

    // Ordinary thresholds. The receiver holds off for a long stretch while the sender
    // keeps offering, so both stages fill and the input stalls.
    apply_levels(8'd200, 8'd120, 8'd190, 8'd130);
    queue_runs(30);
    @(posedge clk_i);
    holdoff_go <= 1'b1;
    @(posedge clk_i);
    holdoff_go <= 1'b0;
    wait_drained();

    // Every threshold at zero.
    apply_levels(8'd0, 8'd0, 8'd0, 8'd0);
    queue_runs(30);
    wait_drained();

    // Every threshold at full scale; from here the sender is the slow side.
    set_idling(82, 12);
    apply_levels(8'd255, 8'd255, 8'd255, 8'd255);
    queue_runs(30);
    wait_drained();

    // Overlapping levels: one long run both trips and clears on the same ticks, and
    // once the counter sits one past its limit every further sample trips at once.
    apply_levels(8'd100, 8'd200, 8'd250, 8'd50);
    add_run(RunTripClear, TripDelay + 6);
    queue_runs(30);
    wait_drained();

    // Inverted release window, so nothing clears; neither side idles from here on.
    set_idling(0, 0);
    apply_levels(8'd230, 8'd150, 8'd140, 8'd210);
    queue_runs(30);
    wait_drained();

    // Random thresholds, with the sender pausing halfway until all results are in.
    apply_levels(mvs_pkg::LevelW'($urandom_range(255)), mvs_pkg::LevelW'($urandom_range(255)),
                 mvs_pkg::LevelW'($urandom_range(255)), mvs_pkg::LevelW'($urandom_range(255)));
    queue_runs(15);
    wait_drained();
    queue_runs(15);
    wait_drained();

    repeat (SettleCycles) @(posedge clk_i);

    $display("Checked %0d results across %0d threshold settings and three idling patterns.",
             results_seen, settings);
    $display("Saw %0d overvoltage and %0d undervoltage trips, %0d power losses, %0d resets.",
             over_trips, under_trips, losses, restarts);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("PASS mains_voltage_supervisor");
    end else begin
      $display("FAIL mains_voltage_supervisor");
    end
    $finish;
  end

endmodule

### mains_voltage_supervisor.f
+incdir+hdl
hdl/mvs_pkg.sv
hdl/mvs_cfg.sv
hdl/mvs_core.sv
hdl/mains_voltage_supervisor.sv
dv/tb.sv
